### hdl/gcic_pkg.sv
// ----------------------------------------------------------------------------
// gcic_pkg: shared constants and types for the grid cell comparator
// Register indexes, reset values, accuracy codes and the closed-cell sum record.
// ----------------------------------------------------------------------------
package gcic_pkg;

   localparam int MAX_GRID_DEF  = 64;
   localparam int MAX_DIM_DEF   = 4096;
   localparam int FRAC_BITS_DEF = 16;

   // register indexes
   localparam logic [2:0] REG_WIDTH     = 3'd0;
   localparam logic [2:0] REG_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_GRID      = 3'd2;
   localparam logic [2:0] REG_PARCHMENT = 3'd3;
   localparam logic [2:0] REG_TOLERANCE = 3'd4;
   localparam logic [2:0] REG_ACCURATE  = 3'd5;

   localparam logic [12:0] RST_WIDTH     = 13'd640;
   localparam logic [12:0] RST_HEIGHT    = 13'd480;
   localparam logic [6:0]  RST_GRID      = 7'd16;
   localparam logic [15:0] RST_PARCHMENT = 16'd58982;
   localparam logic [15:0] RST_TOLERANCE = 16'd3277;
   localparam logic [15:0] RST_ACCURATE  = 16'd52429;

   // accuracy codes
   localparam logic [1:0] ACC_UNMAPPED   = 2'd0;
   localparam logic [1:0] ACC_ACCURATE   = 2'd1;
   localparam logic [1:0] ACC_INACCURATE = 2'd2;

   // closed cell handed from the accumulator to the scorer
   // (count reaches 2^24 for one cell over a full 4096 by 4096 frame)
   typedef struct packed {
      logic [5:0]  col;
      logic [5:0]  row;
      logic        last;
      logic [24:0] count;
      logic [31:0] cr, cg, cb, ca, rr, rg, rb, ra;
   } cell_type;

endpackage

### hdl/gcic_divider.sv
// ----------------------------------------------------------------------------
// gcic_divider: restoring divider, one quotient bit per cycle
// Computes round(num * 2^FRAC / den), half up.
// ----------------------------------------------------------------------------
module gcic_divider
   import gcic_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] num,
   input  logic [47:0] den,
   output logic        done,
   output logic [47:0] quot
);
   localparam int TOT   = 48 + FRAC_BITS + 1;
   localparam int CNT_W = $clog2(TOT + 1);

   logic [TOT-1:0]   shreg_ff, shreg_in;
   logic [48:0]      rem_ff, rem_in;
   logic [47:0]      den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [48:0]      trial;

   // shift in one numerator bit, subtract when possible
   always_comb begin
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[47:0], shreg_ff[TOT-1]};
      if (start) begin
         shreg_in = {num, {(FRAC_BITS + 1){1'b0}}};
         rem_in   = '0;
         cnt_in   = CNT_W'(TOT);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in   = trial - {1'b0, den_ff};
            shreg_in = {shreg_ff[TOT-2:0], 1'b1};
         end else begin
            rem_in   = trial;
            shreg_in = {shreg_ff[TOT-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      if (start) den_ff <= den;
   end

   logic [TOT:0] rounded;
   assign rounded = {1'b0, shreg_ff} + 1'b1;
   assign done = done_ff;
   assign quot = 48'(rounded[TOT:1]);
endmodule

### hdl/gcic_scorer.sv
// ----------------------------------------------------------------------------
// gcic_scorer: turns a closed cell's sums into similarity and accuracy
// Sequence: luma mults and L1 sum, luma divide, L1 divide (skipped for a blank cell), classify.
// ----------------------------------------------------------------------------
module gcic_scorer
   import gcic_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cell_valid,
   output logic        cell_ready,
   input  cell_type    cell_rec,
   input  logic [15:0] parchment_luma,
   input  logic [15:0] blank_tolerance,
   input  logic [15:0] accurate_threshold,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [5:0]  out_col,
   output logic [5:0]  out_row,
   output logic [15:0] out_sim,
   output logic [1:0]  out_acc,
   output logic        out_last
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_LUMA = 3'd2;
   localparam logic [2:0] ST_WLUM = 3'd3;
   localparam logic [2:0] ST_L1   = 3'd4;
   localparam logic [2:0] ST_WL1  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;
   localparam logic [48:0] ONE = 49'(1) << FRAC_BITS;

   logic [2:0]  state_ff, state_in;
   cell_type    cell_ff;
   logic [47:0] pr_ff, pg_ff, pb_ff, d_ff;
   logic [47:0] den_luma_ff, den_l1_ff;
   logic        div_start;
   logic [47:0] div_num, div_den, div_q;
   logic        div_done;
   logic [15:0] sim_ff;
   logic [1:0]  acc_ff;
   logic        ovalid_ff;
   logic        out_load;

   gcic_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
   );

   function automatic logic [32:0] adiff(input logic [31:0] a, input logic [31:0] b);
      adiff = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
   endfunction

   logic [34:0] dsum;
   logic [48:0] lumad, simv;
   assign dsum = 35'(adiff(cell_ff.cr, cell_ff.rr)) + 35'(adiff(cell_ff.cg, cell_ff.rg))
               + 35'(adiff(cell_ff.cb, cell_ff.rb)) + 35'(adiff(cell_ff.ca, cell_ff.ra));
   // luma distance from parchment, taken straight off the divider
   assign lumad = (div_q > 48'(parchment_luma)) ? 49'(div_q - 48'(parchment_luma))
                                                 : 49'(48'(parchment_luma) - div_q);
   assign simv = ONE - {1'b0, div_q};

   assign cell_ready = (state_ff == ST_IDLE);
   assign div_start  = (state_ff == ST_LUMA) || (state_ff == ST_L1);
   assign div_num    = (state_ff == ST_LUMA) ? (pr_ff + pg_ff + pb_ff) : d_ff;
   assign div_den    = (state_ff == ST_LUMA) ? den_luma_ff : den_l1_ff;
   assign out_load   = (state_ff == ST_OUT) && (!ovalid_ff || out_ready);

   // sequence one cell through the shared divider
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (cell_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_LUMA;
         ST_LUMA: state_in = ST_WLUM;
         ST_WLUM: begin
            if (div_done) begin
               if (lumad < 49'(blank_tolerance))
                  state_in = ST_OUT;
               else
                  state_in = ST_L1;
            end
         end
         ST_L1:  state_in = ST_WL1;
         ST_WL1: if (div_done) state_in = ST_OUT;
         ST_OUT: if (!ovalid_ff || out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
      end
      if (state_ff == ST_IDLE && cell_valid) cell_ff <= cell_rec;
      // multiplies, one register stage before the sum
      if (state_ff == ST_MUL) begin
         pr_ff       <= 48'(cell_ff.cr) * 48'd2126;
         pg_ff       <= 48'(cell_ff.cg) * 48'd7152;
         pb_ff       <= 48'(cell_ff.cb) * 48'd722;
         den_luma_ff <= 48'(cell_ff.count) * 48'd2550000;
         den_l1_ff   <= 48'(cell_ff.count) * 48'd1020;
         d_ff        <= 48'(dsum);
      end
      if (state_ff == ST_WLUM && div_done) begin
         sim_ff  <= '0;
         acc_ff  <= ACC_UNMAPPED;
      end
      if (state_ff == ST_WL1 && div_done) begin
         if (div_q == 48'd0) sim_ff <= 16'(ONE - 49'd1);
         else sim_ff <= 16'(simv);
         if (((div_q == 48'd0) ? (ONE - 49'd1) : simv) >= 49'(accurate_threshold))
            acc_ff <= ACC_ACCURATE;
         else
            acc_ff <= ACC_INACCURATE;
      end
      if (out_load) begin
         out_col  <= cell_ff.col;
         out_row  <= cell_ff.row;
         out_sim  <= sim_ff;
         out_acc  <= acc_ff;
         out_last <= cell_ff.last;
      end
   end

   assign out_valid = ovalid_ff;
endmodule

### hdl/gcic_accum.sv
// ----------------------------------------------------------------------------
// gcic_accum: raster walker and per-band cell sum memory
// Read-modify-write of one cell column entry per pixel.
// ----------------------------------------------------------------------------
module gcic_accum
   import gcic_pkg::*;
#(
   parameter int MAX_GRID = MAX_GRID_DEF,
   parameter int MAX_DIM  = MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        restart,
   input  logic [12:0] image_width,
   input  logic [12:0] image_height,
   input  logic [6:0]  grid_size,
   input  logic        pix_valid,
   output logic        pix_ready,
   input  logic [63:0] pix_data,
   output logic        cell_valid,
   input  logic        cell_ready,
   output cell_type    cell_rec
);
   localparam int GW = $clog2(MAX_GRID + 1);
   localparam int AW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int SW = 8 * 32 + 25;

   // geometry saturation
   logic [DW-1:0] w, h;
   logic [GW-1:0] g;
   always_comb begin
      w = (image_width == 13'd0) ? DW'(1) :
          (32'(image_width) > MAX_DIM) ? DW'(MAX_DIM) : DW'(image_width);
      h = (image_height == 13'd0) ? DW'(1) :
          (32'(image_height) > MAX_DIM) ? DW'(MAX_DIM) : DW'(image_height);
      g = (grid_size == 7'd0) ? GW'(1) :
          (32'(grid_size) > MAX_GRID) ? GW'(MAX_GRID) : GW'(grid_size);
      if (32'(g) > 32'(w)) g = GW'(w);
      if (32'(g) > 32'(h)) g = GW'(h);
   end

   // position and boundary state (boundaries tracked by accumulation)
   logic [DW-1:0] x_ff, y_ff, cb_ff, rb_ff;
   logic [GW-1:0] c_ff, r_ff;
   logic [GW-1:0] cacc_ff, racc_ff;   // remainders of (c+1)*w mod g
   logic          clr_ff;             // start of band: entries are clear
   logic [MAX_GRID-1:0] vld_ff;

   logic [SW-1:0] mem [MAX_GRID];
   logic [SW-1:0] rd_ff, wr_data, base;
   logic          st_ff;              // second phase of the pixel
   logic [63:0]   pix_ff;
   logic          pend_ff;

   // next boundary stepping: b += q, rem += r; fix up once
   logic [DW-1:0] wq, hq;
   logic [GW-1:0] wr_, hr_;
   // w/g and h/g computed by restart sweep
   logic [DW-1:0] wq_ff, hq_ff;
   logic [GW-1:0] wr_ff, hr_ff;
   logic          geo_busy_ff;
   logic [DW-1:0] gq_cnt_ff;
   logic [DW:0]   gw_rem_ff, gh_rem_ff;
   logic [DW-1:0] gh_q_ff;

   assign wq = wq_ff;  assign hq = hq_ff;  assign wr_ = wr_ff;  assign hr_ = hr_ff;

   assign pix_ready = !geo_busy_ff && !st_ff && !(pend_ff);

   logic [AW-1:0] ca;
   assign ca = AW'(c_ff);
   assign base = (clr_ff || !vld_ff[ca]) ? '0 : rd_ff;

   logic emit, line_end;
   logic [DW-1:0] xn;
   assign xn = x_ff + 1'b1;
   assign emit = (xn == cb_ff) && (y_ff + 1'b1 == rb_ff);
   assign line_end = (xn >= w);

   always_comb begin
      wr_data = base;
      for (int k = 0; k < 8; k++)
         wr_data[k*32 +: 32] = base[k*32 +: 32] + 32'(pix_ff[k*8 +: 8]);
      wr_data[SW-1 -: 25] = base[SW-1 -: 25] + 25'd1;
   end

   // memory: read in accept cycle, write in second phase
   always_ff @(posedge clock) begin
      if (pix_valid && pix_ready) rd_ff <= mem[ca];
      if (st_ff) mem[ca] <= emit ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         x_ff <= '0; y_ff <= '0; c_ff <= '0; r_ff <= '0;
         st_ff <= 1'b0; pend_ff <= 1'b0; vld_ff <= '0; clr_ff <= 1'b1;
         geo_busy_ff <= 1'b1; gq_cnt_ff <= '0;
         gw_rem_ff <= '0; gh_rem_ff <= '0; gh_q_ff <= '0;
      end else if (geo_busy_ff) begin
         // divide w and h by g via repeated addition of g
         if (gw_rem_ff + (DW+1)'(g) <= (DW+1)'(w)) begin
            gw_rem_ff <= gw_rem_ff + (DW+1)'(g);
            gq_cnt_ff <= gq_cnt_ff + 1'b1;
         end
         if (gh_rem_ff + (DW+1)'(g) <= (DW+1)'(h)) begin
            gh_rem_ff <= gh_rem_ff + (DW+1)'(g);
            gh_q_ff <= gh_q_ff + 1'b1;
         end
         if (!(gw_rem_ff + (DW+1)'(g) <= (DW+1)'(w)) &&
             !(gh_rem_ff + (DW+1)'(g) <= (DW+1)'(h))) begin
            geo_busy_ff <= 1'b0;
            wq_ff <= gq_cnt_ff; hq_ff <= gh_q_ff;
            wr_ff <= GW'((DW+1)'(w) - gw_rem_ff);
            hr_ff <= GW'((DW+1)'(h) - gh_rem_ff);
            cb_ff <= gq_cnt_ff; rb_ff <= gh_q_ff;
            cacc_ff <= GW'((DW+1)'(w) - gw_rem_ff);
            racc_ff <= GW'((DW+1)'(h) - gh_rem_ff);
         end
      end else begin
         if (pix_valid && pix_ready) begin
            pix_ff <= pix_data;
            st_ff <= 1'b1;
         end
         if (st_ff) begin
            st_ff <= 1'b0;
            if (emit) pend_ff <= 1'b1;
            cell_rec.col   <= 6'(c_ff);
            cell_rec.row   <= 6'(r_ff);
            cell_rec.last  <= (c_ff == g - 1'b1) && (r_ff == g - 1'b1);
            cell_rec.count <= wr_data[SW-1 -: 25];
            cell_rec.cr <= wr_data[0 +: 32];   cell_rec.cg <= wr_data[32 +: 32];
            cell_rec.cb <= wr_data[64 +: 32];  cell_rec.ca <= wr_data[96 +: 32];
            cell_rec.rr <= wr_data[128 +: 32]; cell_rec.rg <= wr_data[160 +: 32];
            cell_rec.rb <= wr_data[192 +: 32]; cell_rec.ra <= wr_data[224 +: 32];
            // advance column and column boundary
            if (line_end) begin
               x_ff <= '0; c_ff <= '0; cb_ff <= wq; cacc_ff <= wr_;
            end else begin
               x_ff <= xn;
               if (xn == cb_ff) begin
                  c_ff <= c_ff + 1'b1;
                  if (32'(cacc_ff) + 32'(wr_) >= 32'(g)) begin
                     cb_ff   <= cb_ff + wq + 1'b1;
                     cacc_ff <= GW'(32'(cacc_ff) + 32'(wr_) - 32'(g));
                  end else begin
                     cb_ff   <= cb_ff + wq;
                     cacc_ff <= cacc_ff + wr_;
                  end
               end
            end
            // advance row and row boundary at line end, wrap at frame end
            if (line_end) begin
               if (y_ff + 1'b1 >= h) begin
                  y_ff <= '0; r_ff <= '0; rb_ff <= hq; racc_ff <= hr_;
               end else begin
                  y_ff <= y_ff + 1'b1;
                  if (y_ff + 1'b1 == rb_ff) begin
                     r_ff <= r_ff + 1'b1;
                     if (32'(racc_ff) + 32'(hr_) >= 32'(g)) begin
                        rb_ff   <= rb_ff + hq + 1'b1;
                        racc_ff <= GW'(32'(racc_ff) + 32'(hr_) - 32'(g));
                     end else begin
                        rb_ff   <= rb_ff + hq;
                        racc_ff <= racc_ff + hr_;
                     end
                  end
               end
            end
            // mark the band start; its first pixel sits in column zero
            clr_ff <= line_end && (y_ff + 1'b1 == rb_ff);
            if (clr_ff) vld_ff <= MAX_GRID'(!emit);
            else vld_ff[ca] <= !emit;
         end
         if (pend_ff && cell_ready) pend_ff <= 1'b0;
      end
   end

   assign cell_valid = pend_ff;
endmodule

### hdl/grid_cell_image_compare.sv
// Result: rsp_tvalid rises once a cell's last pixel word is taken and the scorer
//   has run one or two 65-step serial divisions (one for a blank cell).
// Input: each pixel word is read from memory, then written back, before the next
//   is taken; the input stalls while a closed cell waits for the busy scorer.
// Reset: synchronous; position, sums and registers return to reset values,
//   then a geometry sweep runs before the first word.
// ----------------------------------------------------------------------------
// grid_cell_image_compare: per-cell block average L1 image comparison
// Accumulates RGBA pixel pairs per cell and scores each cell as it closes.
// ----------------------------------------------------------------------------
module grid_cell_image_compare
   import gcic_pkg::*;
#(
   parameter int MAX_GRID  = MAX_GRID_DEF,
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cand r,g,b,a then ref r,g,b,a
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_col[5:0], cell_row[11:6], similarity[27:12], accuracy[29:28], pad
   output logic [31:0] rsp_tdata,
   // frame_done
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   logic [12:0] width_ff, height_ff;
   logic [6:0]  grid_ff;
   logic [15:0] parch_ff, tol_ff, acc_thr_ff;
   logic        restart;
   logic        cell_valid, cell_ready;
   cell_type    cell_rec;
   logic [5:0]  o_col, o_row;
   logic [15:0] o_sim;
   logic [1:0]  o_acc;

   assign restart = csr_we && (csr_index == REG_WIDTH || csr_index == REG_HEIGHT ||
                               csr_index == REG_GRID);

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RST_WIDTH; height_ff <= RST_HEIGHT; grid_ff <= RST_GRID;
         parch_ff <= RST_PARCHMENT; tol_ff <= RST_TOLERANCE; acc_thr_ff <= RST_ACCURATE;
      end else if (csr_we) begin
         case (csr_index)
            REG_WIDTH:     width_ff   <= csr_wdata[12:0];
            REG_HEIGHT:    height_ff  <= csr_wdata[12:0];
            REG_GRID:      grid_ff    <= csr_wdata[6:0];
            REG_PARCHMENT: parch_ff   <= csr_wdata;
            REG_TOLERANCE: tol_ff     <= csr_wdata;
            REG_ACCURATE:  acc_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   gcic_accum #(.MAX_GRID(MAX_GRID), .MAX_DIM(MAX_DIM)) u_accum (
      .clock(clock), .reset(reset), .restart(restart),
      .image_width(width_ff), .image_height(height_ff), .grid_size(grid_ff),
      .pix_valid(req_tvalid), .pix_ready(req_tready), .pix_data(req_tdata),
      .cell_valid(cell_valid), .cell_ready(cell_ready), .cell_rec(cell_rec)
   );

   gcic_scorer #(.FRAC_BITS(FRAC_BITS)) u_scorer (
      .clock(clock), .reset(reset),
      .cell_valid(cell_valid), .cell_ready(cell_ready), .cell_rec(cell_rec),
      .parchment_luma(parch_ff), .blank_tolerance(tol_ff),
      .accurate_threshold(acc_thr_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_col(o_col), .out_row(o_row), .out_sim(o_sim), .out_acc(o_acc),
      .out_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, o_acc, o_sim, o_row, o_col};
endmodule

### hdl/gcic_checker.sv
// ----------------------------------------------------------------------------
// gcic_checker: port-level checks on the grid cell comparator
// Watches the pixel and result streams over time.
// ----------------------------------------------------------------------------
module gcic_checker
   import gcic_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);
   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // accuracy code is never 3
   a_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[29:28] != 2'd3)
      else $error("bad accuracy code");

   // unmapped cells score zero
   a_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29:28] == ACC_UNMAPPED |-> rsp_tdata[27:12] == 16'd0)
      else $error("unmapped cell has nonzero score");

   // no two words are taken back to back
   a_rate: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("pixel word accepted back to back");
endmodule

bind grid_cell_image_compare gcic_checker u_gcic_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for grid_cell_image_compare
// Streams pixel-pair words under random gaps and receiver stalls, predicts
// every closed cell with a bit-exact cell scorer, and checks each result word.
// ----------------------------------------------------------------------------
module tb;
   import gcic_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;

   typedef struct {
      logic [5:0]  col;
      logic [5:0]  row;
      logic [15:0] sim;
      logic [1:0]  acc;
      logic        last;
   } cell_score_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // scorer copy of registers and accumulation state
   int unsigned       img_w, img_h, grid_n, parch_luma, blank_tol, acc_thresh;
   int unsigned       pix_col, pix_row, band_col, band_row;
   longint unsigned   chan_sums[MAX_GRID_DEF*8];
   longint unsigned   pix_count[MAX_GRID_DEF];

   cell_score_type    cell_scores_q[$];
   int                error_count = 0;
   int                idle_cycles = 0;
   bit                quiet = 1'b0;
   int                hold_cycles = 0;

   grid_cell_image_compare dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // cell scorer
   // ------------------------------------------------------------------
   // round(num * 2^16 / den), half up
   function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < FRAC_BITS_DEF + 1; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 1;
         end
      end
      return (q + 1) >> 1;
   endfunction

   function automatic longint unsigned abs_diff(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic restart_frame();
      pix_col = 0;
      pix_row = 0;
      band_col = 0;
      band_row = 0;
      foreach (chan_sums[i]) chan_sums[i] = 0;
      foreach (pix_count[i]) pix_count[i] = 0;
   endtask

   task automatic score_pixel(logic [63:0] word);
      int unsigned w, h, g, c, r, x, next_cb, next_rb;
      longint unsigned n, luma, l1_sum, sim;
      cell_score_type cs;
      w = clamp(img_w, 1, MAX_DIM_DEF);
      h = clamp(img_h, 1, MAX_DIM_DEF);
      g = clamp(grid_n, 1, MAX_GRID_DEF);
      if (g > w) g = w;
      if (g > h) g = h;
      if (pix_col >= w || pix_row >= h || band_col >= g || band_row >= g) restart_frame();
      c = band_col;
      r = band_row;
      for (int ch = 0; ch < 8; ch++) chan_sums[c*8+ch] += word[8*ch +: 8];
      pix_count[c] += 1;
      x = pix_col + 1;
      next_cb = ((c + 1) * w) / g;
      next_rb = ((r + 1) * h) / g;
      // close the cell on its bottom-right pixel
      if (x == next_cb && pix_row + 1 == next_rb) begin
         n = pix_count[c];
         luma = frac_div(2126 * chan_sums[c*8] + 7152 * chan_sums[c*8+1]
                         + 722 * chan_sums[c*8+2], 2550000 * n);
         cs.sim = '0;
         cs.acc = ACC_UNMAPPED;
         if (!(abs_diff(luma, parch_luma) < blank_tol)) begin
            l1_sum = 0;
            for (int ch = 0; ch < 4; ch++)
               l1_sum += abs_diff(chan_sums[c*8+ch], chan_sums[c*8+ch+4]);
            sim = 65536 - frac_div(l1_sum, 1020 * n);
            if (sim > 65535) sim = 65535;
            cs.sim = sim[15:0];
            cs.acc = (sim >= acc_thresh) ? ACC_ACCURATE : ACC_INACCURATE;
         end
         cs.col = c[5:0];
         cs.row = r[5:0];
         cs.last = (r == g - 1 && c == g - 1);
         cell_scores_q.push_back(cs);
         for (int ch = 0; ch < 8; ch++) chan_sums[c*8+ch] = 0;
         pix_count[c] = 0;
      end
      // advance position
      if (x == next_cb) c++;
      pix_col = x;
      if (x >= w) begin
         pix_col = 0;
         c = 0;
         pix_row++;
         if (pix_row == next_rb) r++;
         if (pix_row >= h) begin
            pix_row = 0;
            r = 0;
         end
      end
      band_col = c;
      band_row = r;
   endtask

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (quiet || p < 50) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // candidate and reference, close to each other in half the draws
   function automatic logic [63:0] rand_pixel();
      logic [31:0] cand, refp;
      logic [7:0]  v;
      int mode;
      mode = $urandom_range(9);
      cand = $urandom;
      refp = $urandom;
      if (mode < 5) begin
         for (int ch = 0; ch < 4; ch++)
            refp[8*ch +: 8] = cand[8*ch +: 8] ^ 8'($urandom_range(7) << $urandom_range(5));
      end else if (mode < 7) begin
         // near-parchment gray candidate
         v = 8'($urandom_range(240, 220));
         cand = {8'($urandom_range(255)), v, v, v};
      end
      return {refp, cand};
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_WIDTH:     begin img_w = val & 16'h1FFF; restart_frame(); end
         REG_HEIGHT:    begin img_h = val & 16'h1FFF; restart_frame(); end
         REG_GRID:      begin grid_n = val & 16'h7F; restart_frame(); end
         REG_PARCHMENT: parch_luma = val;
         REG_TOLERANCE: blank_tol = val;
         REG_ACCURATE:  acc_thresh = val;
         default: ;
      endcase
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned g);
      write_reg(REG_WIDTH, w[15:0]);
      write_reg(REG_HEIGHT, h[15:0]);
      write_reg(REG_GRID, g[15:0]);
   endtask

   task automatic set_scoring(int unsigned pl, int unsigned tol, int unsigned th);
      write_reg(REG_PARCHMENT, pl[15:0]);
      write_reg(REG_TOLERANCE, tol[15:0]);
      write_reg(REG_ACCURATE, th[15:0]);
   endtask

   // send one pixel word, hold valid across back-to-back words
   task automatic send_pixel(logic [63:0] word);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      score_pixel(word);
   endtask

   // drain results, then let the block finish any open work
   task automatic settle();
      req_tvalid <= 1'b0;
      while (cell_scores_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      logic [63:0] words[$];
      set_geometry(64, 64, 64);
      set_scoring(58982, 3277, 52429);
      words = '{64'h0, {64{1'b1}}, 64'h00000000_FFFFFFFF, 64'hFFFFFFFF_00000000,
                64'h12345678_12345678, 64'hFFE6E6E6_FFE6E6E6, 64'hFFE6E6E6_00E6E6E6,
                64'h80808080_7F7F7F7F, 64'hFF0000FF_FF000000, 64'h00FF00FF_0000FFFF,
                64'hAAAAAAAA_55555555, 64'h01010101_FEFEFEFE};
      foreach (words[i]) send_pixel(words[i]);
      settle();
      // threshold extremes
      set_scoring(0, 0, 0);
      for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
      settle();
      set_scoring(65535, 65535, 65535);
      for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
      settle();
      set_scoring(65535, 1, 65535);
      send_pixel({64{1'b1}});
      send_pixel(64'hFFFFFFFF_FFFFFFFE);
      settle();
   endtask

   // tiny frame, saturated geometry: last pixel flags the frame and wraps
   task automatic test_frame_wrap();
      set_geometry(0, 64, 0);
      set_scoring(58982, 3277, 52429);
      for (int i = 0; i < 128; i++) send_pixel(rand_pixel());
      settle();
      set_geometry(8191, 64, 127);
      for (int i = 0; i < 70; i++) send_pixel(rand_pixel());
      settle();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      set_geometry(64, 64, 64);
      hold_cycles = 400;
      quiet = 1'b1;
      for (int i = 0; i < 60; i++) send_pixel(rand_pixel());
      quiet = 1'b0;
      settle();
   endtask

   task automatic test_random();
      int unsigned w, h, g, p;
      for (int phase = 0; phase < 9; phase++) begin
         p = $urandom_range(9);
         w = (p == 0) ? 4096 : $urandom_range(96, 64);
         h = $urandom_range(72, 64);
         case ($urandom_range(5))
            0: g = 127;
            1: g = $urandom_range(8, 1);
            default: g = $urandom_range(64, 32);
         endcase
         set_geometry(w, h, g);
         set_scoring($urandom_range(65535), $urandom_range(6000), $urandom_range(65535, 40000));
         quiet = (phase % 4 == 3);
         for (int i = 0; i < 63; i++) send_pixel(rand_pixel());
         quiet = 1'b0;
         settle();
      end
   endtask

   // ------------------------------------------------------------------
   // result checker and receiver stalls
   // ------------------------------------------------------------------
   initial begin
      cell_score_type e;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (cell_scores_q.size() == 0) begin
               $display("%0t: unexpected result word %h last %b", $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               e = cell_scores_q.pop_front();
               if (rsp_tdata[5:0] !== e.col) begin
                  $display("%0t: cell_col expected %0d actual %0d", $time, e.col, rsp_tdata[5:0]);
                  error_count++;
               end
               if (rsp_tdata[11:6] !== e.row) begin
                  $display("%0t: cell_row expected %0d actual %0d", $time, e.row,
                           rsp_tdata[11:6]);
                  error_count++;
               end
               if (rsp_tdata[27:12] !== e.sim) begin
                  $display("%0t: similarity expected %0d actual %0d", $time, e.sim,
                           rsp_tdata[27:12]);
                  error_count++;
               end
               if (rsp_tdata[29:28] !== e.acc) begin
                  $display("%0t: accuracy expected %0d actual %0d", $time, e.acc,
                           rsp_tdata[29:28]);
                  error_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: frame_done expected %b actual %b", $time, e.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         // choose next ready
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) < 70);
            if ($urandom_range(199) == 0) hold_cycles = $urandom_range(60, 10);
         end
      end
   end

   // watchdog on cycles with no accepted word
   initial begin
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_cell_image_compare test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      img_w = RST_WIDTH;
      img_h = RST_HEIGHT;
      grid_n = RST_GRID;
      parch_luma = RST_PARCHMENT;
      blank_tol = RST_TOLERANCE;
      acc_thresh = RST_ACCURATE;
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_frame_wrap();
      test_backpressure();
      test_random();
      settle();
      if (error_count == 0) begin
         $display("grid_cell_image_compare test passed");
      end else begin
         $display("grid_cell_image_compare test failed");
      end
      $finish;
   end

endmodule
